// ===== hw/rtl/mersenne_twister_64_generator_top_macros.svh =====
// Assertion macros for the MT19937-64 generator.
`ifndef MERSENNE_TWISTER_64_GENERATOR_TOP_MACROS_SVH
`define MERSENNE_TWISTER_64_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MT64_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mt64 assertion failed");
// next-cycle implication
`define MT64_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mt64 assertion failed");
`else
`define MT64_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MT64_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/mt64_pkg.sv =====
// Types, constants and word functions for the MT19937-64 generator.
`default_nettype none

package mt64_pkg;

  typedef logic [63:0] word_t;

  localparam int unsigned STATE_DEPTH  = 312;
  localparam int unsigned TWIST_OFFSET = 156;
  localparam int unsigned IDX_W        = 9;

  localparam word_t INIT_MULT  = 64'd6364136223846793005;
  localparam word_t TWIST_MAG  = 64'hB5026F5AA96619E9;
  localparam word_t UPPER_MASK = 64'hFFFFFFFF80000000;
  localparam word_t LOWER_MASK = 64'h000000007FFFFFFF;
  localparam word_t TEMPER_U   = 64'h5555555555555555;
  localparam word_t TEMPER_B   = 64'h71D67FFFEDA60000;
  localparam word_t TEMPER_C   = 64'hFFF7EEE000000000;

  localparam word_t DEFAULT_SEED_RST = 64'd5489;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DRAW
  } state_t;

  // new word from word k, word k+1 and word k+offset
  function automatic word_t twist_word(input word_t w_k, input word_t w_k1,
                                       input word_t w_off);
    word_t y;
    y = (w_k & UPPER_MASK) | (w_k1 & LOWER_MASK);
    return w_off ^ (y >> 1) ^ (y[0] ? TWIST_MAG : '0);
  endfunction

  function automatic word_t temper(input word_t w);
    word_t x;
    x = w;
    x = x ^ ((x >> 29) & TEMPER_U);
    x = x ^ ((x << 17) & TEMPER_B);
    x = x ^ ((x << 37) & TEMPER_C);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mersenne_twister_64_generator_top.sv =====
// Top level of the MT19937-64 generator: shift chain, seeding control, output register.
//
//  channel   signals                         direction
//  in        in_valid/in_ready, op, seed     consumer
//  out       out_valid/out_ready, value      producer
//  cfg       cfg_wr_en, cfg_wr_data          write only, default_seed
//
// A draw twists one word into the chain and shifts it; the tempered word is registered.
// A seed loads the seed word, then makes each further word through the seeding multiplier in ST_MUL and ST_ADD.
// A draw before any seed runs the same fill from default_seed first, then draws.
// A draw stalled by a full output register waits in a hold state; in_ready drops meanwhile.
// Synchronous reset clears control and restores default_seed; the state words are undefined until seeded.
`default_nettype none
`include "mersenne_twister_64_generator_top_macros.svh"

module mersenne_twister_64_generator_top
  import mt64_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  op,
  input  wire word_t seed,
  output logic       out_valid,
  input  wire logic  out_ready,
  output word_t      value,
  input  wire logic  cfg_wr_en,
  input  wire word_t cfg_wr_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_DEPTH - 1);

  state_t           state;
  state_t           state_next;
  logic             seeded;
  logic             pending_draw;
  logic [IDX_W-1:0] k;
  word_t            default_seed;

  word_t words [STATE_DEPTH];
  word_t chain_in;
  word_t twisted;
  word_t seed_word;

  logic in_fire;
  logic slot_free;
  logic seed_start;
  logic draw_fire;
  logic shift_en;

  // chain: cell i takes from cell i+1, the last cell takes the new word
  for (genvar i = 0; i < STATE_DEPTH; i++) begin : g_chain
    if (i == STATE_DEPTH - 1) begin : g_tail
      mt64_cell u_cell (.clk(clk), .en(shift_en), .d(chain_in), .q(words[i]));
    end else begin : g_body
      mt64_cell u_cell (.clk(clk), .en(shift_en), .d(words[i+1]), .q(words[i]));
    end
  end

  mt64_seeder u_seeder (
    .clk       (clk),
    .prev      (words[STATE_DEPTH-1]),
    .k         (k),
    .next_word (seed_word)
  );

  assign twisted = twist_word(words[0], words[1], words[TWIST_OFFSET]);

  // outputs of the control
  always_comb begin
    in_ready   = (state == ST_IDLE);
    in_fire    = in_valid && in_ready;
    slot_free  = !out_valid || out_ready;
    seed_start = in_fire && ((op == OP_SEED) || !seeded);
    draw_fire  = (in_fire && (op == OP_DRAW) && seeded && slot_free) ||
                 ((state == ST_DRAW) && slot_free);
    shift_en   = seed_start || (state == ST_ADD) || draw_fire;
    if (draw_fire) begin
      chain_in = twisted;
    end else if (seed_start) begin
      chain_in = (op == OP_SEED) ? seed : default_seed;
    end else begin
      chain_in = seed_word;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (seed_start) begin
          state_next = ST_MUL;
        end else if (in_fire && !slot_free) begin
          state_next = ST_DRAW;
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: begin
        if (k == LAST_IDX) begin
          state_next = pending_draw ? ST_DRAW : ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DRAW: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seeded       <= 1'b0;
      pending_draw <= 1'b0;
      k            <= '0;
      out_valid    <= 1'b0;
      default_seed <= DEFAULT_SEED_RST;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        default_seed <= cfg_wr_data;
      end
      if (seed_start) begin
        k            <= IDX_W'(1);
        pending_draw <= (op == OP_DRAW);
      end else if ((state == ST_ADD) && (k != LAST_IDX)) begin
        k <= k + IDX_W'(1);
      end else if (draw_fire) begin
        pending_draw <= 1'b0;
      end
      if ((state == ST_ADD) && (k == LAST_IDX)) begin
        seeded <= 1'b1;
      end
      if (draw_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw_fire) begin
      value <= temper(twisted);
    end
  end

  `MT64_ASSERT_IMP(a_no_overwrite, clk, rst, draw_fire, (!out_valid || out_ready))
  `MT64_ASSERT_NXT(a_seed_done, clk, rst, ((state == ST_ADD) && (k == LAST_IDX)), seeded)
  `MT64_ASSERT_IMP(a_shift_src, clk, rst, shift_en,
                   (seed_start || (state == ST_ADD) || draw_fire))
  `MT64_ASSERT_IMP(a_draw_seeded, clk, rst, draw_fire, seeded)

endmodule

`default_nettype wire

// ===== hw/rtl/mt64_cell.sv =====
// One state word of the circular shift chain.
`default_nettype none

module mt64_cell
  import mt64_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  en,
  input  wire word_t d,
  output word_t      q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mt64_seeder.sv =====
// Seeding recurrence: next = INIT_MULT * (prev ^ (prev >> 62)) + k, with the partial products registered.
`default_nettype none

module mt64_seeder
  import mt64_pkg::*;
(
  input  wire logic             clk,
  input  wire word_t            prev,
  input  wire logic [IDX_W-1:0] k,
  output word_t                 next_word
);

  word_t       x;
  word_t       lo_prod;
  logic [31:0] mid_sum;
  word_t       p_lo;
  logic [31:0] p_mid;

  // 64x64 low half split into 32x32 partial products; cross terms only need low 32 bits
  always_comb begin
    x       = prev ^ (prev >> 62);
    lo_prod = {32'b0, x[31:0]} * {32'b0, INIT_MULT[31:0]};
    mid_sum = x[63:32] * INIT_MULT[31:0] + x[31:0] * INIT_MULT[63:32];
  end

  always_ff @(posedge clk) begin
    p_lo  <= lo_prod;
    p_mid <= mid_sum;
  end

  assign next_word = p_lo + {p_mid, 32'b0} + 64'(k);

endmodule

`default_nettype wire
